/* rtl/mcse_pkg.sv */
// ----------------------------------------------------------------------------
// mcse_pkg
// Types, codes and constants shared by the marginal cost slope estimator.
// ----------------------------------------------------------------------------
package mcse_pkg;

  localparam int NUM_W     = 113;
  localparam int DEN_W     = 96;
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 32;
  localparam int LIN_STEPS = 48;
  localparam int ADDR_W    = 3;

  localparam logic [63:0] SLOPE_CAP   = 64'h4000_0000_0000_0000;
  localparam logic [40:0] TERM_CAP    = 41'h100_0000_0000;
  localparam logic [31:0] MAX_RESET   = 32'hFFFF_FFFF;
  localparam logic [15:0] RATIO_RESET = 16'd256;
  localparam logic [2:0]  QSTEP_LAST  = 3'd5;

  localparam logic REG_MAX_MARGINAL  = 1'b0;
  localparam logic REG_PENALTY_RATIO = 1'b1;

  typedef enum logic [1:0] {
    TAG_FIN  = 2'd0,
    TAG_PINF = 2'd1,
    TAG_NINF = 2'd2,
    TAG_RSV  = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    K_FIN   = 2'd0,
    K_PINF  = 2'd1,
    K_NINF  = 2'd2,
    K_UNDEF = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_LIN   = 2'd0,
    MODE_AVG   = 2'd1,
    MODE_QUAD  = 2'd2,
    MODE_CONST = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    LS_PM = 2'd0,
    LS_MI = 2'd1,
    LS_IM = 2'd2,
    LS_PI = 2'd3
  } lsel_t;

  typedef struct packed {
    logic signed [31:0] travel_time;
    logic [1:0]         time_tag;
    logic [31:0]        total_vehicles;
    logic [31:0]        class_vehicles;
    logic               last_in_series;
  } sample_t;

  typedef struct packed {
    logic [31:0] marginal_cost;
    logic        last_of_run;
  } cost_t;

  typedef struct packed {
    logic       load;
    logic       plan;
    logic       commit;
    logic       lin_go;
    logic       lin_fin;
    logic       to_save;
    logic       avg;
    logic       qmul_go;
    logic       qmul_fin;
    logic       qdiv_go;
    logic       qfin;
    logic       term_go;
    logic       marg;
    logic       pen;
    logic       second;
    lsel_t      lin_sel;
    logic [2:0] qstep;
  } cmd_t;

  typedef struct packed {
    logic  lone;
    logic  store;
    logic  last;
    mode_t mode;
    lsel_t sel;
    logic  div_busy;
    logic  mul_busy;
  } status_t;

endpackage

/* rtl/mcse_mul.sv */
// ----------------------------------------------------------------------------
// mcse_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mcse_mul #(
  parameter int WA = mcse_pkg::MUL_A_W,
  parameter int WB = mcse_pkg::MUL_B_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic             busy,
  output logic [WA+WB-1:0] prod
);
  localparam int CW = $clog2(WB + 1);

  logic [WA+WB-1:0] acc;
  logic [WA+WB-1:0] ash;
  logic [WB-1:0]    bsh;
  logic [CW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(WB);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= {{WB{1'b0}}, a};
      bsh <= b;
    end else if (cnt != '0) begin
      if (bsh[0]) begin
        acc <= acc + ash;
      end
      ash <= {ash[WA+WB-2:0], 1'b0};
      bsh <= {1'b0, bsh[WB-1:1]};
    end
  end

  assign busy = (cnt != '0);
  assign prod = acc;

endmodule

/* rtl/mcse_div.sv */
// ----------------------------------------------------------------------------
// mcse_div
// Restoring divider, one quotient bit per cycle, numerator taken from the top.
// ----------------------------------------------------------------------------
module mcse_div #(
  parameter int WN = mcse_pkg::NUM_W,
  parameter int WD = mcse_pkg::DEN_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [WN-1:0]            num,
  input  logic [WD-1:0]            den,
  input  logic [$clog2(WN+1)-1:0]  steps,
  output logic                     busy,
  output logic [WN-1:0]            quo
);
  localparam int CW = $clog2(WN + 1);

  logic [WN-1:0] nq;
  logic [WD-1:0] rem;
  logic [WD-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [WD:0]   sh;
  logic [WD:0]   diff;
  logic          ge;

  assign sh   = {rem, nq[WN-1]};
  assign diff = sh - {1'b0, dreg};
  assign ge   = (sh >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq   <= num;
      rem  <= '0;
      dreg <= den;
    end else if (cnt != '0) begin
      rem <= ge ? diff[WD-1:0] : sh[WD-1:0];
      nq  <= {nq[WN-2:0], ge};
    end
  end

  assign busy = (cnt != '0);
  assign quo  = nq;

endmodule

/* rtl/mcse_dp.sv */
// ----------------------------------------------------------------------------
// mcse_dp
// Datapath: period history, slope arithmetic, marginal clamp and penalty.
// ----------------------------------------------------------------------------
module mcse_dp (
  input  logic              clk,
  input  logic              rst,
  input  mcse_pkg::sample_t sample,
  input  mcse_pkg::cmd_t    cmd,
  input  logic [31:0]       max_marginal,
  input  logic [15:0]       penalty_ratio,
  output mcse_pkg::status_t st,
  output mcse_pkg::cost_t   cost
);
  import mcse_pkg::*;

  logic [31:0] in_t, in_n, in_c;
  tag_t        in_g;
  logic        in_last;
  logic [1:0]  held_count;
  logic [31:0] prev_time, prev_vehicles;
  tag_t        prev_tag;
  logic [31:0] mid_time, mid_vehicles, mid_class_vehicles;
  tag_t        mid_tag;

  kind_t       slope_k, save_k, lin_k;
  logic [63:0] slope_v, save_v;
  logic        lin_div, lin_neg, qneg;
  logic [63:0] ra;
  logic [95:0] qa, qb, qd;
  logic [31:0] v;
  logic [31:0] out_val;
  logic        out_last;

  tag_t        samp_g;
  mode_t       mode;
  lsel_t       psel_plan;
  kind_t       ckind;

  assign samp_g = (tag_t'(sample.time_tag) == TAG_RSV) ? TAG_FIN : tag_t'(sample.time_tag);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_t    <= sample.travel_time;
      in_g    <= samp_g;
      in_n    <= sample.total_vehicles;
      in_c    <= sample.class_vehicles;
      in_last <= sample.last_in_series;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (cmd.commit) begin
      if (in_last) begin
        held_count <= 2'd0;
      end else if (held_count == 2'd0) begin
        held_count <= 2'd1;
      end else begin
        held_count <= 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !in_last) begin
      prev_time          <= mid_time;
      prev_tag           <= mid_tag;
      prev_vehicles      <= mid_vehicles;
      mid_time           <= in_t;
      mid_tag            <= in_g;
      mid_vehicles       <= in_n;
      mid_class_vehicles <= in_c;
    end
  end

  always_comb begin
    mode      = MODE_LIN;
    psel_plan = LS_MI;
    ckind     = K_FIN;
    if (held_count == 2'd2) begin
      if (mid_tag == TAG_PINF) begin
        mode  = MODE_CONST;
        ckind = K_UNDEF;
      end else if (prev_tag == TAG_PINF || in_g == TAG_PINF) begin
        mode = MODE_AVG;
      end else if (mid_vehicles == prev_vehicles) begin
        if (in_n == prev_vehicles) begin
          mode = MODE_CONST;
        end
      end else if (in_n == prev_vehicles) begin
        psel_plan = LS_IM;
      end else if (in_n == mid_vehicles) begin
        psel_plan = LS_PI;
      end else if (prev_tag != TAG_FIN || mid_tag != TAG_FIN || in_g != TAG_FIN) begin
        mode  = MODE_CONST;
        ckind = K_UNDEF;
      end else begin
        mode = MODE_QUAD;
      end
    end
  end

  // linear slope between two selected points
  logic [31:0] la_t, la_n, lb_t, lb_n;
  tag_t        la_g, lb_g;
  logic [32:0] dn, dt;
  logic [31:0] dnm, dtm;
  logic        l_special;
  kind_t       l_kind;

  always_comb begin
    la_t = prev_time;  la_g = prev_tag;  la_n = prev_vehicles;
    lb_t = mid_time;   lb_g = mid_tag;   lb_n = mid_vehicles;
    case (cmd.lin_sel)
      LS_PM: begin
        la_t = prev_time;  la_g = prev_tag;  la_n = prev_vehicles;
        lb_t = mid_time;   lb_g = mid_tag;   lb_n = mid_vehicles;
      end
      LS_MI: begin
        la_t = mid_time;   la_g = mid_tag;   la_n = mid_vehicles;
        lb_t = in_t;       lb_g = in_g;      lb_n = in_n;
      end
      LS_IM: begin
        la_t = in_t;       la_g = in_g;      la_n = in_n;
        lb_t = mid_time;   lb_g = mid_tag;   lb_n = mid_vehicles;
      end
      LS_PI: begin
        la_t = prev_time;  la_g = prev_tag;  la_n = prev_vehicles;
        lb_t = in_t;       lb_g = in_g;      lb_n = in_n;
      end
      default: begin
        la_t = prev_time;  la_g = prev_tag;  la_n = prev_vehicles;
      end
    endcase
  end

  assign dn  = {1'b0, lb_n} - {1'b0, la_n};
  assign dt  = {lb_t[31], lb_t} - {la_t[31], la_t};
  assign dnm = dn[32] ? 32'(-dn) : dn[31:0];
  assign dtm = dt[32] ? 32'(-dt) : dt[31:0];

  always_comb begin
    l_special = 1'b1;
    l_kind    = K_FIN;
    if (dn == '0) begin
      l_kind = K_FIN;
    end else if (la_g != TAG_FIN && lb_g != TAG_FIN) begin
      l_kind = K_UNDEF;
    end else if (lb_g != TAG_FIN) begin
      l_kind = ((lb_g == TAG_PINF) ^ dn[32]) ? K_PINF : K_NINF;
    end else if (la_g != TAG_FIN) begin
      l_kind = ((la_g == TAG_NINF) ^ dn[32]) ? K_PINF : K_NINF;
    end else begin
      l_special = 1'b0;
    end
  end

  // quadratic through three points
  logic [32:0] d0, d2, ds, dy1, dy2;
  logic [31:0] d0m, d2m, dsm, dy1m, dy2m;
  logic        na, nb, nd, nn;
  logic [96:0] qnum;

  assign d0  = {1'b0, mid_vehicles} - {1'b0, prev_vehicles};
  assign d2  = {1'b0, in_n} - {1'b0, mid_vehicles};
  assign ds  = {1'b0, in_n} - {1'b0, prev_vehicles};
  assign dy1 = {mid_time[31], mid_time} - {prev_time[31], prev_time};
  assign dy2 = {in_t[31], in_t} - {mid_time[31], mid_time};
  assign d0m  = d0[32]  ? 32'(-d0)  : d0[31:0];
  assign d2m  = d2[32]  ? 32'(-d2)  : d2[31:0];
  assign dsm  = ds[32]  ? 32'(-ds)  : ds[31:0];
  assign dy1m = dy1[32] ? 32'(-dy1) : dy1[31:0];
  assign dy2m = dy2[32] ? 32'(-dy2) : dy2[31:0];
  assign na = dy1[32];
  assign nb = dy2[32];
  assign nd = d0[32] ^ d2[32] ^ ds[32];

  always_comb begin
    if (na == nb) begin
      qnum = {1'b0, qa} + {1'b0, qb};
      nn   = na;
    end else if (qa >= qb) begin
      qnum = {1'b0, qa - qb};
      nn   = na;
    end else begin
      qnum = {1'b0, qb - qa};
      nn   = nb;
    end
  end

  // shared multiplier and divider
  logic                    mu_start, mu_busy;
  logic [MUL_A_W-1:0]      mu_a;
  logic [MUL_B_W-1:0]      mu_b;
  logic [95:0]             mu_prod;
  logic [63:0]             slope_mag;
  logic [31:0]             sel_c;

  assign slope_mag = slope_v[63] ? -slope_v : slope_v;
  assign sel_c     = cmd.second ? in_c : mid_class_vehicles;
  assign mu_start  = cmd.qmul_go || cmd.term_go;

  always_comb begin
    mu_a = slope_mag;
    mu_b = sel_c;
    if (cmd.qmul_go) begin
      case (cmd.qstep)
        3'd0: begin mu_a = {32'd0, d2m}; mu_b = d2m;  end
        3'd1: begin mu_a = ra;           mu_b = dy1m; end
        3'd2: begin mu_a = {32'd0, d0m}; mu_b = d0m;  end
        3'd3: begin mu_a = ra;           mu_b = dy2m; end
        3'd4: begin mu_a = {32'd0, d0m}; mu_b = d2m;  end
        default: begin mu_a = ra;        mu_b = dsm;  end
      endcase
    end
  end

  mcse_mul #(.WA(MUL_A_W), .WB(MUL_B_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mu_start),
    .a     (mu_a),
    .b     (mu_b),
    .busy  (mu_busy),
    .prod  (mu_prod)
  );

  localparam int SW = $clog2(NUM_W + 1);

  logic              dv_start, dv_busy;
  logic [NUM_W-1:0]  dv_num, dv_quo;
  logic [DEN_W-1:0]  dv_den;
  logic [SW-1:0]     dv_steps;

  assign dv_start = (cmd.lin_go && !l_special) || cmd.qdiv_go;
  assign dv_num   = cmd.qdiv_go ? {qnum, 16'd0}
                                : {dtm, 16'd0, {(NUM_W - LIN_STEPS){1'b0}}};
  assign dv_den   = cmd.qdiv_go ? qd : {{(DEN_W - 32){1'b0}}, dnm};
  assign dv_steps = cmd.qdiv_go ? SW'(NUM_W) : SW'(LIN_STEPS);

  mcse_div #(.WN(NUM_W), .WD(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .steps (dv_steps),
    .busy  (dv_busy),
    .quo   (dv_quo)
  );

  // slope results
  kind_t       fin_k;
  logic [63:0] fin_v;
  logic [64:0] avg_sum, avg_adj;
  logic [63:0] qcap;
  kind_t       avg_k;
  logic [63:0] avg_v;

  always_comb begin
    if (lin_div) begin
      fin_k = K_FIN;
      fin_v = lin_neg ? -dv_quo[63:0] : dv_quo[63:0];
    end else begin
      fin_k = lin_k;
      fin_v = '0;
    end
  end

  assign avg_sum = {save_v[63], save_v} + {slope_v[63], slope_v};
  assign avg_adj = avg_sum + {64'd0, avg_sum[64]};
  assign qcap    = (dv_quo > {{(NUM_W - 64){1'b0}}, SLOPE_CAP}) ? SLOPE_CAP : dv_quo[63:0];

  always_comb begin
    avg_v = '0;
    if (save_k == K_UNDEF || slope_k == K_UNDEF) begin
      avg_k = K_UNDEF;
    end else if (save_k == K_FIN && slope_k == K_FIN) begin
      avg_k = K_FIN;
      avg_v = avg_adj[64:1];
    end else if (save_k == K_FIN) begin
      avg_k = slope_k;
    end else if (slope_k == K_FIN || save_k == slope_k) begin
      avg_k = save_k;
    end else begin
      avg_k = K_UNDEF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan && mode == MODE_CONST) begin
      slope_k <= ckind;
      slope_v <= '0;
    end
    if (cmd.lin_go) begin
      lin_div <= !l_special;
      lin_k   <= l_kind;
      lin_neg <= dt[32] ^ dn[32];
    end
    if (cmd.lin_fin) begin
      if (cmd.to_save) begin
        save_k <= fin_k;
        save_v <= fin_v;
      end else begin
        slope_k <= fin_k;
        slope_v <= fin_v;
      end
    end
    if (cmd.avg) begin
      slope_k <= avg_k;
      slope_v <= avg_v;
    end
    if (cmd.qmul_fin) begin
      case (cmd.qstep)
        3'd1:    qa <= mu_prod;
        3'd3:    qb <= mu_prod;
        3'd5:    qd <= mu_prod;
        default: ra <= mu_prod[63:0];
      endcase
    end
    if (cmd.qdiv_go) begin
      qneg <= nn ^ nd;
    end
    if (cmd.qfin) begin
      slope_k <= K_FIN;
      if (qd == '0) begin
        slope_v <= '0;
      end else begin
        slope_v <= qneg ? -qcap : qcap;
      end
    end
  end

  // marginal, clamp and penalty
  logic [31:0] mt;
  tag_t        mg, skt;
  logic [79:0] tm80;
  logic [40:0] tm;
  logic [42:0] xsum;
  logic [31:0] v_next;
  logic [47:0] pprod;
  logic [31:0] lone_v;

  assign mt   = cmd.second ? in_t : mid_time;
  assign mg   = cmd.second ? in_g : mid_tag;
  assign skt  = (slope_k == K_PINF) ? TAG_PINF : TAG_NINF;
  assign tm80 = mu_prod[95:16];
  assign tm   = (tm80 > {39'd0, TERM_CAP}) ? TERM_CAP : tm80[40:0];

  always_comb begin
    xsum = {{11{mt[31]}}, mt};
    if (sel_c != '0) begin
      xsum = slope_v[63] ? xsum - {2'b0, tm} : xsum + {2'b0, tm};
    end
    if (slope_k == K_UNDEF) begin
      v_next = max_marginal;
    end else if (sel_c != '0 && slope_k != K_FIN) begin
      if (mg != TAG_FIN && mg != skt) begin
        v_next = max_marginal;
      end else begin
        v_next = (slope_k == K_PINF) ? max_marginal : '0;
      end
    end else if (mg == TAG_PINF) begin
      v_next = max_marginal;
    end else if (mg == TAG_NINF) begin
      v_next = '0;
    end else if (xsum[42]) begin
      v_next = '0;
    end else if (xsum[41:0] > {10'd0, max_marginal}) begin
      v_next = max_marginal;
    end else begin
      v_next = xsum[31:0];
    end
  end

  always_comb begin
    if (in_g == TAG_PINF) begin
      lone_v = max_marginal;
    end else if (in_g == TAG_NINF || in_t[31]) begin
      lone_v = '0;
    end else if (in_t > max_marginal) begin
      lone_v = max_marginal;
    end else begin
      lone_v = in_t;
    end
  end

  assign pprod = v * penalty_ratio;

  always_ff @(posedge clk) begin
    if (cmd.marg) begin
      v <= v_next;
    end
    if (cmd.plan && st.lone) begin
      out_val  <= lone_v;
      out_last <= 1'b1;
    end
    if (cmd.pen) begin
      out_val  <= (pprod[47:40] != '0) ? 32'hFFFF_FFFF : pprod[39:8];
      out_last <= cmd.second;
    end
  end

  assign st.lone     = (held_count == 2'd0) && in_last;
  assign st.store    = (held_count == 2'd0) && !in_last;
  assign st.last     = in_last;
  assign st.mode     = mode;
  assign st.sel      = psel_plan;
  assign st.div_busy = dv_busy;
  assign st.mul_busy = mu_busy;

  assign cost.marginal_cost = out_val;
  assign cost.last_of_run   = out_last;

endmodule

/* rtl/mcse_ctrl.sv */
// ----------------------------------------------------------------------------
// mcse_ctrl
// Sequencer: steps each sample through slope, term, clamp and penalty.
// ----------------------------------------------------------------------------
module mcse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  output logic              cost_valid,
  input  logic              cost_ready,
  input  mcse_pkg::status_t st,
  output mcse_pkg::cmd_t    cmd
);
  import mcse_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PLAN  = 13'b0000000000010,
    S_LIN   = 13'b0000000000100,
    S_LINW  = 13'b0000000001000,
    S_AVG   = 13'b0000000010000,
    S_QMUL  = 13'b0000000100000,
    S_QMULW = 13'b0000001000000,
    S_QDIV  = 13'b0000010000000,
    S_QDIVW = 13'b0000100000000,
    S_TERM  = 13'b0001000000000,
    S_TERMW = 13'b0010000000000,
    S_PEN   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t     state, state_next;
  logic       second, second_next;
  logic       avg_ph, avg_ph_next;
  logic [2:0] qstep, qstep_next;
  logic       avg_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
      avg_ph <= 1'b0;
      qstep  <= '0;
    end else begin
      state  <= state_next;
      second <= second_next;
      avg_ph <= avg_ph_next;
      qstep  <= qstep_next;
    end
  end

  assign avg_first = !second && st.mode == MODE_AVG && !avg_ph;

  always_comb begin
    state_next  = state;
    second_next = second;
    avg_ph_next = avg_ph;
    qstep_next  = qstep;
    cmd         = '0;
    cmd.second  = second;
    cmd.qstep   = qstep;
    if (second) begin
      cmd.lin_sel = LS_MI;
    end else if (st.mode == MODE_AVG) begin
      cmd.lin_sel = avg_ph ? LS_MI : LS_PM;
    end else begin
      cmd.lin_sel = st.sel;
    end
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load    = 1'b1;
          avg_ph_next = 1'b0;
          second_next = 1'b0;
          state_next  = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan = 1'b1;
        if (st.lone) begin
          state_next = S_OUT;
        end else if (st.store) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else begin
          case (st.mode)
            MODE_LIN:  state_next = S_LIN;
            MODE_AVG:  state_next = S_LIN;
            MODE_QUAD: begin
              qstep_next = '0;
              state_next = S_QMUL;
            end
            default:   state_next = S_TERM;
          endcase
        end
      end
      S_LIN: begin
        cmd.lin_go = 1'b1;
        state_next = S_LINW;
      end
      S_LINW: begin
        if (!st.div_busy) begin
          cmd.lin_fin = 1'b1;
          cmd.to_save = avg_first;
          if (avg_first) begin
            avg_ph_next = 1'b1;
            state_next  = S_LIN;
          end else if (!second && st.mode == MODE_AVG) begin
            state_next = S_AVG;
          end else begin
            state_next = S_TERM;
          end
        end
      end
      S_AVG: begin
        cmd.avg    = 1'b1;
        state_next = S_TERM;
      end
      S_QMUL: begin
        cmd.qmul_go = 1'b1;
        state_next  = S_QMULW;
      end
      S_QMULW: begin
        if (!st.mul_busy) begin
          cmd.qmul_fin = 1'b1;
          if (qstep == QSTEP_LAST) begin
            state_next = S_QDIV;
          end else begin
            qstep_next = qstep + 3'd1;
            state_next = S_QMUL;
          end
        end
      end
      S_QDIV: begin
        cmd.qdiv_go = 1'b1;
        state_next  = S_QDIVW;
      end
      S_QDIVW: begin
        if (!st.div_busy) begin
          cmd.qfin   = 1'b1;
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        cmd.term_go = 1'b1;
        state_next  = S_TERMW;
      end
      S_TERMW: begin
        if (!st.mul_busy) begin
          cmd.marg   = 1'b1;
          state_next = S_PEN;
        end
      end
      S_PEN: begin
        cmd.pen    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (cost_ready) begin
          if (!st.lone && !second && st.last) begin
            second_next = 1'b1;
            state_next  = S_LIN;
          end else begin
            cmd.commit  = 1'b1;
            second_next = 1'b0;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign sample_ready = (state == S_IDLE);
  assign cost_valid   = (state == S_OUT);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(sample_ready && cost_valid))
    else $error("input taken while a result is pending");

  a_lone_out: assert property (@(posedge clk) disable iff (rst)
    state == S_PLAN && st.lone |=> state == S_OUT)
    else $error("lone period did not go straight to output");

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.qmul_go || cmd.term_go) |-> !st.mul_busy)
    else $error("multiplier restarted while busy");

  a_second_done: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && cost_ready && second |=> !second && state == S_IDLE)
    else $error("final beat did not close the series");

endmodule

/* rtl/marginal_cost_slope_estimator.sv */
// ----------------------------------------------------------------------------
// marginal_cost_slope_estimator
// Per-period marginal cost of one link from a finite-difference or quadratic
// slope of travel time over vehicle count, clamped and penalized.
//
//   channel   dir  handshake                 beat
//   sample    in   sample_valid/ready        sample_t (one period)
//   cost      out  cost_valid/ready          cost_t (one marginal)
//   apb       in   psel/penable/pwrite       max_marginal @0, penalty_ratio @4
//
// One sample at a time; sample_ready is high only when the sequencer is idle.
// A first period is only stored; a lone period goes straight to output. A linear
// beat takes a 48-step divide and a 32-step multiply; averaging takes two divides.
// Quadratic slope: six 32-step multiplies and a 113-step divide.
// A final period adds one more linear beat. Stalls on cost hold the sequencer.
// Synchronous reset clears the sequencer and the held period count.
// ----------------------------------------------------------------------------
module marginal_cost_slope_estimator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  mcse_pkg::sample_t             sample,
  output logic                          cost_valid,
  input  logic                          cost_ready,
  output mcse_pkg::cost_t               cost,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcse_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mcse_pkg::*;

  logic [31:0] max_marginal;
  logic [15:0] penalty_ratio;
  logic        wr;
  cmd_t        cmd;
  status_t     st;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_marginal  <= MAX_RESET;
      penalty_ratio <= RATIO_RESET;
    end else if (wr) begin
      if (paddr[2] == REG_MAX_MARGINAL) begin
        max_marginal <= pwdata;
      end else begin
        penalty_ratio <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PENALTY_RATIO) ? {16'd0, penalty_ratio} : max_marginal;

  mcse_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .cost_valid   (cost_valid),
    .cost_ready   (cost_ready),
    .st           (st),
    .cmd          (cmd)
  );

  mcse_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .cmd           (cmd),
    .max_marginal  (max_marginal),
    .penalty_ratio (penalty_ratio),
    .st            (st),
    .cost          (cost)
  );

endmodule
